[design/kpf_pkg.sv]
// shared types, constants and register codes for the key press fade envelope
package kpf_pkg;

  localparam int MaxPressesDef = 16;
  localparam int KeyCountDef   = 256;

  localparam int KeyW  = 8;
  localparam int AgeW  = 32;
  localparam int ColW  = 8;
  localparam int MsW   = 16;
  localparam int LifeW = MsW + 1;
  localparam int NumW  = ColW + MsW;
  localparam int QuotW = ColW;

  localparam logic [ColW-1:0] ColorResetVal   = 8'd255;
  localparam logic [MsW-1:0]  SustainResetVal = 16'd750;
  localparam logic [MsW-1:0]  DecayResetVal   = 16'd500;

  typedef enum logic [2:0] {
    REG_RED     = 3'd0,
    REG_GREEN   = 3'd1,
    REG_BLUE    = 3'd2,
    REG_ALPHA   = 3'd3,
    REG_SUSTAIN = 3'd4,
    REG_DECAY   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic            func;
    logic [KeyW-1:0] key_index;
    logic [MsW-1:0]  elapsed_ms;
  } cmd_item_t;

  typedef struct packed {
    logic [KeyW-1:0] out_key;
    logic [ColW-1:0] out_red;
    logic [ColW-1:0] out_green;
    logic [ColW-1:0] out_blue;
    logic [ColW-1:0] out_alpha;
    logic            last;
  } res_item_t;

  typedef struct packed {
    logic [ColW-1:0] color_red;
    logic [ColW-1:0] color_green;
    logic [ColW-1:0] color_blue;
    logic [ColW-1:0] color_alpha;
    logic [MsW-1:0]  sustain_ms;
    logic [MsW-1:0]  decay_ms;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic idx_clr;
    logic idx_inc;
    logic rd_en;
    logic age_calc;
    logic classify;
    logic div_start;
    logic out_load;
    logic wr_hit;
    logic append;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_tick;
    logic key_bad;
    logic cnt_zero;
    logic hit;
    logic idx_last;
    logic fade;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

[design/kpf_div.sv]
// restoring divider, one quotient bit per cycle, quotient known to fit in QuotW bits
module kpf_div (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [kpf_pkg::NumW-1:0] num,
  input  logic [kpf_pkg::MsW-1:0]  den,
  output logic                     busy,
  output logic [kpf_pkg::QuotW-1:0] quot
);

  localparam int StepW = $clog2(kpf_pkg::QuotW);

  logic [kpf_pkg::NumW-1:0] rem;
  logic [kpf_pkg::NumW-1:0] dsh;
  logic [StepW-1:0]         step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && step == '0) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= kpf_pkg::NumW'(den) << (kpf_pkg::QuotW - 1);
      step <= StepW'(kpf_pkg::QuotW - 1);
      quot <= '0;
    end else if (busy) begin
      if (rem >= dsh) begin
        rem  <= rem - dsh;
        quot <= {quot[kpf_pkg::QuotW-2:0], 1'b1};
      end else begin
        quot <= {quot[kpf_pkg::QuotW-2:0], 1'b0};
      end
      dsh  <= dsh >> 1;
      step <= step - StepW'(1);
    end
  end

endmodule

[design/kpf_datapath.sv]
// press table memory, age update, colour shaping and result register
module kpf_datapath #(
  parameter int MAX_PRESSES = kpf_pkg::MaxPressesDef,
  parameter int KEY_COUNT   = kpf_pkg::KeyCountDef
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kpf_pkg::cfg_t         cfg,
  input  kpf_pkg::cmd_item_t    cmd_item,
  input  kpf_pkg::ctrl_cmd_t    ctl,
  output kpf_pkg::dp_status_t   stat,
  output logic                  res_valid,
  input  logic                  res_stall,
  output kpf_pkg::res_item_t    res
);

  localparam int CntW = $clog2(MAX_PRESSES + 1);
  localparam int IdxW = (MAX_PRESSES > 1) ? $clog2(MAX_PRESSES) : 1;

  typedef struct packed {
    logic [kpf_pkg::KeyW-1:0] key;
    logic [kpf_pkg::AgeW-1:0] age;
  } entry_t;

  entry_t                    mem [MAX_PRESSES];
  entry_t                    rd_entry;
  kpf_pkg::cmd_item_t        item;
  logic [CntW-1:0]           count;
  logic [CntW-1:0]           kept;
  logic [IdxW-1:0]           idx;
  logic [kpf_pkg::AgeW-1:0]  age_new;
  logic                      full_f;
  logic                      fade_f;
  logic                      keep_f;
  logic [kpf_pkg::MsW-1:0]   diff;

  logic                      wr_en;
  logic [IdxW-1:0]           wr_addr;
  entry_t                    wr_data;
  logic                      room;
  logic [kpf_pkg::LifeW-1:0] lifetime;
  logic [kpf_pkg::LifeW-1:0] diff_full;
  logic [kpf_pkg::AgeW:0]    age_sum;
  logic [kpf_pkg::NumW-1:0]  num;
  logic [kpf_pkg::QuotW-1:0] quot;
  logic                      div_busy;

  assign room      = count < CntW'(MAX_PRESSES);
  assign lifetime  = kpf_pkg::LifeW'(cfg.sustain_ms) + kpf_pkg::LifeW'(cfg.decay_ms);
  assign diff_full = lifetime - age_new[kpf_pkg::LifeW-1:0];
  assign age_sum   = {1'b0, rd_entry.age} + (kpf_pkg::AgeW + 1)'(item.elapsed_ms);
  assign num       = kpf_pkg::NumW'(cfg.color_alpha) * kpf_pkg::NumW'(diff);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '{key: item.key_index, age: '0};
    if (ctl.wr_hit) begin
      wr_en = 1'b1;
    end else if (ctl.append) begin
      wr_en   = room;
      wr_addr = count[IdxW-1:0];
    end else if (ctl.out_load) begin
      // compaction: kept entries move down behind the read pointer
      wr_en   = keep_f;
      wr_addr = kept[IdxW-1:0];
      wr_data = '{key: rd_entry.key, age: age_new};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_entry <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.append && room) begin
      count <= count + CntW'(1);
    end else if (ctl.out_load && stat.idx_last) begin
      count <= kept + CntW'(keep_f);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_in) begin
      item <= cmd_item;
    end
    if (ctl.idx_clr) begin
      idx  <= '0;
      kept <= '0;
    end else begin
      if (ctl.idx_inc) begin
        idx <= idx + IdxW'(1);
      end
      if (ctl.out_load) begin
        kept <= kept + CntW'(keep_f);
      end
    end
    if (ctl.age_calc) begin
      age_new <= age_sum[kpf_pkg::AgeW] ? '1 : age_sum[kpf_pkg::AgeW-1:0];
    end
    if (ctl.classify) begin
      full_f <= age_new <= kpf_pkg::AgeW'(cfg.sustain_ms);
      keep_f <= age_new < kpf_pkg::AgeW'(lifetime);
      fade_f <= (age_new > kpf_pkg::AgeW'(cfg.sustain_ms)) &&
                (age_new < kpf_pkg::AgeW'(lifetime)) && (cfg.decay_ms != '0);
      diff   <= diff_full[kpf_pkg::MsW-1:0];
    end
  end

  kpf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (ctl.div_start),
    .num   (num),
    .den   (cfg.decay_ms),
    .busy  (div_busy),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      res.out_key   <= rd_entry.key;
      res.out_red   <= (full_f || fade_f) ? cfg.color_red   : '0;
      res.out_green <= (full_f || fade_f) ? cfg.color_green : '0;
      res.out_blue  <= (full_f || fade_f) ? cfg.color_blue  : '0;
      res.out_alpha <= full_f ? cfg.color_alpha : (fade_f ? quot : '0);
      res.last      <= stat.idx_last;
    end
  end

  always_comb begin
    stat.is_tick  = cmd_item.func;
    stat.key_bad  = {1'b0, cmd_item.key_index} >= 9'(KEY_COUNT);
    stat.cnt_zero = count == '0;
    stat.hit      = rd_entry.key == item.key_index;
    stat.idx_last = (CntW'(idx) + CntW'(1)) == count;
    stat.fade     = fade_f;
    stat.div_busy = div_busy;
    stat.out_free = !res_valid || !res_stall;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(MAX_PRESSES))
    else $error("press count beyond table depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    ctl.out_load |-> (!res_valid || !res_stall))
    else $error("result register overwritten while stalled");

  a_compact_behind: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && keep_f) |-> (kept <= CntW'(idx)))
    else $error("compaction write ahead of read pointer");

  a_count_shrinks: assert property (@(posedge clk) disable iff (rst)
    (ctl.out_load && stat.idx_last) |=> (count <= $past(count)))
    else $error("tick grew the press table");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    ctl.div_start |-> !div_busy)
    else $error("divider restarted while busy");

endmodule

[design/kpf_ctrl.sv]
// sequencer for press lookup, tick walk and result hand-off
module kpf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_stall,
  input  kpf_pkg::dp_status_t stat,
  output kpf_pkg::ctrl_cmd_t  ctl
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_PRD  = 10'b0000000010,
    S_PCMP = 10'b0000000100,
    S_PAPP = 10'b0000001000,
    S_TRD  = 10'b0000010000,
    S_TAGE = 10'b0000100000,
    S_TCLS = 10'b0001000000,
    S_TMUL = 10'b0010000000,
    S_TDIV = 10'b0100000000,
    S_TOUT = 10'b1000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign cmd_stall = state != S_IDLE;

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          ctl.load_in = 1'b1;
          ctl.idx_clr = 1'b1;
          if (stat.is_tick) begin
            state_next = stat.cnt_zero ? S_IDLE : S_TRD;
          end else if (stat.key_bad) begin
            state_next = S_IDLE;
          end else begin
            state_next = stat.cnt_zero ? S_PAPP : S_PRD;
          end
        end
      end
      S_PRD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_PCMP;
      end
      S_PCMP: begin
        if (stat.hit) begin
          ctl.wr_hit = 1'b1;
          state_next = S_IDLE;
        end else if (stat.idx_last) begin
          state_next = S_PAPP;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_PRD;
        end
      end
      S_PAPP: begin
        ctl.append = 1'b1;
        state_next = S_IDLE;
      end
      S_TRD: begin
        ctl.rd_en  = 1'b1;
        state_next = S_TAGE;
      end
      S_TAGE: begin
        ctl.age_calc = 1'b1;
        state_next   = S_TCLS;
      end
      S_TCLS: begin
        ctl.classify = 1'b1;
        state_next   = S_TMUL;
      end
      S_TMUL: begin
        if (stat.fade) begin
          ctl.div_start = 1'b1;
          state_next    = S_TDIV;
        end else begin
          state_next = S_TOUT;
        end
      end
      S_TDIV: begin
        if (!stat.div_busy) begin
          state_next = S_TOUT;
        end
      end
      S_TOUT: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          if (stat.idx_last) begin
            state_next = S_IDLE;
          end else begin
            ctl.idx_inc = 1'b1;
            state_next  = S_TRD;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> (state != S_TOUT && state != S_TDIV))
    else $error("accepted item jumped into the result stage");

  a_load_only_idle: assert property (@(posedge clk) disable iff (rst)
    ctl.load_in |-> (state == S_IDLE && cmd_valid))
    else $error("item latched outside idle");

  a_div_then_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_TDIV && !stat.div_busy) |=> state == S_TOUT)
    else $error("divider result not taken");

endmodule

[design/key_press_fade_envelope.sv]
// key press fade envelope: top level with register file, sequencer and datapath
//
// cmd channel (cmd_valid/cmd_stall/cmd) carries one item: func 0 is a key press,
// func 1 a render tick with elapsed_ms. res channel (res_valid/res_stall/res)
// carries the colour results of a tick, one per table entry in table order,
// last set on the final one; a press or a tick on an empty table gives none.
// items are handled one at a time; cmd_stall stays high until the current
// item is finished.
// a press scans the table one entry at a time (registered memory read, then
// compare) and appends a new key after the last entry; a key at or above
// KEY_COUNT is dropped in the cycle that takes it.
// a tick walks the entries in table order: memory read, age update, classify,
// a restoring divide only while the colour is fading, then the result register.
// when res_stall is high the result register holds its item and the walk
// waits at that entry; the next item is not taken until the last result of
// the tick sits in the result register.
// reset empties the table and sets colour 255/255/255/255, sustain 750 ms and
// decay 500 ms; no clearing pass is needed. registers sit on the apb port at byte
// address 4*index; the user must write them only while idle, which the block does not enforce.
module key_press_fade_envelope #(
  parameter int MAX_PRESSES = kpf_pkg::MaxPressesDef,
  parameter int KEY_COUNT   = kpf_pkg::KeyCountDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  kpf_pkg::cmd_item_t cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output kpf_pkg::res_item_t res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  kpf_pkg::cfg_t       cfg;
  kpf_pkg::ctrl_cmd_t  ctl;
  kpf_pkg::dp_status_t stat;
  kpf_pkg::reg_idx_t   reg_sel;
  logic                wr_stb;

  assign pready  = 1'b1;
  assign reg_sel = kpf_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_stb  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.color_red   <= kpf_pkg::ColorResetVal;
      cfg.color_green <= kpf_pkg::ColorResetVal;
      cfg.color_blue  <= kpf_pkg::ColorResetVal;
      cfg.color_alpha <= kpf_pkg::ColorResetVal;
      cfg.sustain_ms  <= kpf_pkg::SustainResetVal;
      cfg.decay_ms    <= kpf_pkg::DecayResetVal;
    end else if (wr_stb) begin
      case (reg_sel)
        kpf_pkg::REG_RED:     cfg.color_red   <= pwdata[kpf_pkg::ColW-1:0];
        kpf_pkg::REG_GREEN:   cfg.color_green <= pwdata[kpf_pkg::ColW-1:0];
        kpf_pkg::REG_BLUE:    cfg.color_blue  <= pwdata[kpf_pkg::ColW-1:0];
        kpf_pkg::REG_ALPHA:   cfg.color_alpha <= pwdata[kpf_pkg::ColW-1:0];
        kpf_pkg::REG_SUSTAIN: cfg.sustain_ms  <= pwdata[kpf_pkg::MsW-1:0];
        kpf_pkg::REG_DECAY:   cfg.decay_ms    <= pwdata[kpf_pkg::MsW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      kpf_pkg::REG_RED:     prdata = 32'(cfg.color_red);
      kpf_pkg::REG_GREEN:   prdata = 32'(cfg.color_green);
      kpf_pkg::REG_BLUE:    prdata = 32'(cfg.color_blue);
      kpf_pkg::REG_ALPHA:   prdata = 32'(cfg.color_alpha);
      kpf_pkg::REG_SUSTAIN: prdata = 32'(cfg.sustain_ms);
      kpf_pkg::REG_DECAY:   prdata = 32'(cfg.decay_ms);
      default:              prdata = '0;
    endcase
  end

  kpf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .stat      (stat),
    .ctl       (ctl)
  );

  kpf_datapath #(
    .MAX_PRESSES (MAX_PRESSES),
    .KEY_COUNT   (KEY_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_item  (cmd),
    .ctl       (ctl),
    .stat      (stat),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[tb/tb_top.sv]
// self-checking testbench for the key press fade envelope: driver, monitor and colour predictor
`timescale 1ns / 100ps

module tb_top;

  localparam logic FuncPress  = 1'b0;
  localparam logic FuncTick   = 1'b1;
  localparam int   RegPastEnd = kpf_pkg::REG_DECAY + 1;
  localparam int   HoldCycles = 300;
  localparam int   SettleCycles = 60;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cmd_valid = 1'b0;
  logic               cmd_stall;
  kpf_pkg::cmd_item_t cmd = '0;
  logic               res_valid;
  logic               res_stall = 1'b0;
  kpf_pkg::res_item_t res;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [4:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  key_press_fade_envelope dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted block state
  logic [kpf_pkg::ColW-1:0] cfg_red     = kpf_pkg::ColorResetVal;
  logic [kpf_pkg::ColW-1:0] cfg_green   = kpf_pkg::ColorResetVal;
  logic [kpf_pkg::ColW-1:0] cfg_blue    = kpf_pkg::ColorResetVal;
  logic [kpf_pkg::ColW-1:0] cfg_alpha   = kpf_pkg::ColorResetVal;
  logic [kpf_pkg::MsW-1:0]  cfg_sustain = kpf_pkg::SustainResetVal;
  logic [kpf_pkg::MsW-1:0]  cfg_decay   = kpf_pkg::DecayResetVal;
  logic [kpf_pkg::KeyW-1:0] tbl_key [kpf_pkg::MaxPressesDef];
  logic [kpf_pkg::AgeW-1:0] tbl_age [kpf_pkg::MaxPressesDef];
  int                       tbl_n = 0;

  kpf_pkg::cmd_item_t cmd_q [$];
  kpf_pkg::res_item_t colour_q [$];
  int                 err_cnt = 0;
  logic               cmd_acc = 1'b0;
  int                 tx_idle_pct = 36;
  int                 rx_idle_pct = 36;
  logic               rx_hold = 1'b0;
  event               hold_go;

  task automatic predict_envelope(input kpf_pkg::cmd_item_t c);
    logic [kpf_pkg::AgeW:0] sum;
    int unsigned            life;
    longint unsigned        num;
    kpf_pkg::res_item_t     r;
    logic                   hit;
    int                     n;
    int                     kept;
    if (c.func == FuncPress) begin
      hit = 1'b0;
      for (int i = 0; i < tbl_n; i++) begin
        if (!hit && tbl_key[i] == c.key_index) begin
          tbl_age[i] = '0;
          hit = 1'b1;
        end
      end
      // a new key is dropped once the table is full
      if (!hit && tbl_n < kpf_pkg::MaxPressesDef) begin
        tbl_key[tbl_n] = c.key_index;
        tbl_age[tbl_n] = '0;
        tbl_n++;
      end
    end else begin
      life = int'(cfg_sustain) + int'(cfg_decay);
      n = tbl_n;
      for (int i = 0; i < n; i++) begin
        sum = {1'b0, tbl_age[i]} + (kpf_pkg::AgeW+1)'(c.elapsed_ms);
        tbl_age[i] = sum[kpf_pkg::AgeW] ? '1 : sum[kpf_pkg::AgeW-1:0];
        r = '0;
        r.out_key = tbl_key[i];
        r.last = (i == n - 1);
        if (tbl_age[i] <= cfg_sustain) begin
          r.out_red   = cfg_red;
          r.out_green = cfg_green;
          r.out_blue  = cfg_blue;
          r.out_alpha = cfg_alpha;
        end else if (tbl_age[i] < life && cfg_decay != 0) begin
          r.out_red   = cfg_red;
          r.out_green = cfg_green;
          r.out_blue  = cfg_blue;
          num = longint'(cfg_alpha) * longint'(life - tbl_age[i]);
          r.out_alpha = kpf_pkg::ColW'(num / longint'(cfg_decay));
        end
        colour_q.insert(colour_q.size(), r);
      end
      // expired entries leave, order of the rest kept
      kept = 0;
      for (int i = 0; i < n; i++) begin
        if (tbl_age[i] < life) begin
          tbl_key[kept] = tbl_key[i];
          tbl_age[kept] = tbl_age[i];
          kept++;
        end
      end
      tbl_n = kept;
    end
  endtask

  // monitor: accepted items feed the predictor, accepted results are checked
  always @(posedge clk) begin
    kpf_pkg::res_item_t want;
    cmd_acc = 1'b0;
    if (!rst) begin
      if (cmd_valid && !cmd_stall) begin
        cmd_acc = 1'b1;
        predict_envelope(cmd);
      end
      if (res_valid && !res_stall) begin
        if (colour_q.size() == 0) begin
          if (err_cnt < 10)
            $display("unexpected result: key %0d rgba %0d %0d %0d %0d last %0d",
                     res.out_key, res.out_red, res.out_green, res.out_blue,
                     res.out_alpha, res.last);
          err_cnt++;
        end else begin
          want = colour_q.pop_front();
          if (res.out_key !== want.out_key || res.out_red !== want.out_red ||
              res.out_green !== want.out_green || res.out_blue !== want.out_blue ||
              res.out_alpha !== want.out_alpha || res.last !== want.last) begin
            if (err_cnt < 10)
              $display("mismatch: exp key %0d rgba %0d %0d %0d %0d last %0d, %s",
                       want.out_key, want.out_red, want.out_green, want.out_blue,
                       want.out_alpha, want.last,
                       $sformatf("got key %0d rgba %0d %0d %0d %0d last %0d",
                                 res.out_key, res.out_red, res.out_green,
                                 res.out_blue, res.out_alpha, res.last));
            err_cnt++;
          end
        end
      end
    end
  end

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_acc) begin
      if (cmd_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        cmd <= cmd_q.pop_front();
        cmd_valid <= 1'b1;
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rx_hold) res_stall <= 1'b1;
    else res_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // long receiver hold-off so the block backs up into its input
  always begin
    @(hold_go);
    rx_hold <= 1'b1;
    for (int c = 0; c < HoldCycles; c++) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic add_item(input logic f, input logic [kpf_pkg::KeyW-1:0] k,
                          input logic [kpf_pkg::MsW-1:0] el);
    kpf_pkg::cmd_item_t it;
    it.func = f;
    it.key_index = k;
    it.elapsed_ms = el;
    cmd_q.insert(cmd_q.size(), it);
  endtask

  function automatic logic [kpf_pkg::MsW-1:0] pick_elapsed(input int life);
    if ($urandom_range(99) < 80) return kpf_pkg::MsW'($urandom_range(life / 4 + 2));
    return kpf_pkg::MsW'($urandom);
  endfunction

  task automatic reg_write(input int idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(idx * 4);
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      kpf_pkg::REG_RED:     cfg_red     = val[kpf_pkg::ColW-1:0];
      kpf_pkg::REG_GREEN:   cfg_green   = val[kpf_pkg::ColW-1:0];
      kpf_pkg::REG_BLUE:    cfg_blue    = val[kpf_pkg::ColW-1:0];
      kpf_pkg::REG_ALPHA:   cfg_alpha   = val[kpf_pkg::ColW-1:0];
      kpf_pkg::REG_SUSTAIN: cfg_sustain = val[kpf_pkg::MsW-1:0];
      kpf_pkg::REG_DECAY:   cfg_decay   = val[kpf_pkg::MsW-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] r, input logic [31:0] g,
                            input logic [31:0] b, input logic [31:0] a,
                            input logic [31:0] sus, input logic [31:0] dec);
    reg_write(kpf_pkg::REG_RED, r);
    reg_write(kpf_pkg::REG_GREEN, g);
    reg_write(kpf_pkg::REG_BLUE, b);
    reg_write(kpf_pkg::REG_ALPHA, a);
    reg_write(kpf_pkg::REG_SUSTAIN, sus);
    reg_write(kpf_pkg::REG_DECAY, dec);
  endtask

  // mostly presses followed by ticks, with some bare ticks and random noise
  task automatic queue_session(input int n_items);
    int cnt;
    int sel;
    int burst;
    int life;
    cnt = 0;
    life = int'(cfg_sustain) + int'(cfg_decay);
    while (cnt < n_items) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          // a small key pool makes restarts of live entries common
          add_item(FuncPress,
                   ($urandom_range(99) < 70) ? kpf_pkg::KeyW'($urandom_range(23) * 11)
                                             : kpf_pkg::KeyW'($urandom_range(255)),
                   kpf_pkg::MsW'($urandom));
          cnt++;
        end
        burst = $urandom_range(1, 3);
        repeat (burst) begin
          add_item(FuncTick, kpf_pkg::KeyW'($urandom), pick_elapsed(life));
          cnt++;
        end
      end else if (sel < 85) begin
        add_item(FuncTick, kpf_pkg::KeyW'($urandom), pick_elapsed(life));
        cnt++;
      end else begin
        add_item(1'($urandom), kpf_pkg::KeyW'($urandom), kpf_pkg::MsW'($urandom));
        cnt++;
      end
    end
  endtask

  // sender pause: everything taken, every result in, then the block settles
  task automatic wait_drained();
    @(posedge clk);
    while (cmd_q.size() != 0 || cmd_valid || colour_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings
    add_item(FuncTick, 8'h00, 16'd0);
    add_item(FuncPress, 8'h00, 16'h0000);
    add_item(FuncPress, 8'hFF, 16'hFFFF);
    add_item(FuncTick, 8'h00, 16'd0);
    add_item(FuncTick, 8'hFF, 16'd750);
    add_item(FuncPress, 8'h00, 16'h0000);
    add_item(FuncTick, 8'h00, 16'd1);
    add_item(FuncTick, 8'h00, 16'd498);
    add_item(FuncTick, 8'h00, 16'd1);
    for (int i = 1; i < kpf_pkg::MaxPressesDef; i++)
      add_item(FuncPress, kpf_pkg::KeyW'(i * 17), 16'h0000);
    // table now full, this key is dropped
    add_item(FuncPress, 8'd128, 16'h0000);
    add_item(FuncTick, 8'h00, 16'hFFFF);
    add_item(FuncTick, 8'h00, 16'd0);
    wait_drained();

    set_config($urandom, $urandom, $urandom, $urandom, 32'd200, 32'd300);
    reg_write(RegPastEnd, $urandom);
    queue_session(55);
    wait_drained();

    // zero colour, zero sustain and zero decay
    set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    queue_session(50);
    wait_drained();

    // longest lifetime, no idling on either side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_config(32'd255, 32'd255, 32'd255, 32'd255, 32'd65535, 32'd65535);
    queue_session(50);
    wait_drained();

    tx_idle_pct = 36;
    rx_idle_pct = 36;
    set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255), 32'd0, 32'd3);
    queue_session(50);
    wait_drained();

    set_config($urandom_range(255), $urandom_range(255), $urandom_range(255),
               $urandom_range(255), $urandom_range(600), $urandom_range(600));
    queue_session(60);
    -> hold_go;
    wait_drained();

    if (err_cnt == 0 && colour_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
design/kpf_pkg.sv
design/kpf_div.sv
design/kpf_datapath.sv
design/kpf_ctrl.sv
design/key_press_fade_envelope.sv
tb/tb_top.sv
